### src/kgs_pkg.sv
// Shared definitions for the keyframe get-up sequencer.
// Command codes, register indexes, field widths and the keyframe pose table.
// No dependencies.
`timescale 1ns / 1ps

package kgs_pkg;

    // Command codes of an input request.
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_CAPTURE = 2'd1;
    localparam logic [1:0] CMD_START   = 2'd2;

    // Configuration register indexes (byte address bits [3:2]).
    localparam logic [1:0] REG_TUCK   = 2'd0;
    localparam logic [1:0] REG_PUSHUP = 2'd1;
    localparam logic [1:0] REG_KNEEL  = 2'd2;
    localparam logic [1:0] REG_STAND  = 2'd3;

    // Register reset values.
    localparam logic [15:0] TUCK_RESET   = 16'd2000;
    localparam logic [15:0] PUSHUP_RESET = 16'd1500;
    localparam logic [15:0] KNEEL_RESET  = 16'd3000;
    localparam logic [15:0] STAND_RESET  = 16'd3000;

    localparam int ADDR_W = 4;

    typedef logic signed [15:0] angle_t;

    // Keyframe end pose of a segment, Q4.12. Face-up mirrors face-down in
    // sign for all but the stand pose. Joints without an entry read as zero.
    function automatic angle_t kf_value(input logic dir, input logic [1:0] key,
                                        input logic [5:0] j);
        angle_t v;
        v = 16'sd0;
        case (key)
            2'd0:
                case (j)
                    6'd7, 6'd14:  v = 16'sd8192;
                    6'd20, 6'd26: v = 16'sd10240;
                    6'd21, 6'd27: v = -16'sd10240;
                    6'd22, 6'd28: v = 16'sd4096;
                    default:      v = 16'sd0;
                endcase
            2'd1:
                case (j)
                    6'd4, 6'd11:  v = 16'sd4915;
                    6'd7, 6'd14:  v = 16'sd2048;
                    6'd20, 6'd26: v = 16'sd10240;
                    6'd21, 6'd27: v = -16'sd10240;
                    6'd22, 6'd28: v = 16'sd8192;
                    default:      v = 16'sd0;
                endcase
            2'd2:
                case (j)
                    6'd4, 6'd11:  v = 16'sd4915;
                    6'd7, 6'd14:  v = 16'sd2048;
                    6'd20, 6'd26: v = 16'sd4096;
                    6'd21, 6'd27: v = -16'sd8192;
                    6'd22, 6'd28: v = 16'sd4096;
                    default:      v = 16'sd0;
                endcase
            default:
                case (j)
                    6'd20, 6'd26: v = -16'sd410;
                    6'd21, 6'd27: v = 16'sd819;
                    6'd22, 6'd28: v = -16'sd410;
                    default:      v = 16'sd0;
                endcase
        endcase
        if (dir && key != 2'd3)
        begin
            v = -v;
        end
        return v;
    endfunction

endpackage

### src/kgs_if.sv
// Handshake channels of the sequencer: input request and joint target.
// Depends on kgs_pkg.
`timescale 1ns / 1ps

interface kgs_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [4:0]        joint_index;
    kgs_pkg::angle_t   joint_angle;
    logic              face_up;

    modport source (output valid, cmd, joint_index, joint_angle, face_up, input ready);
    modport sink   (input valid, cmd, joint_index, joint_angle, face_up, output ready);
endinterface

interface kgs_out_if;
    logic              valid;
    logic              ready;
    logic [4:0]        target_index;
    kgs_pkg::angle_t   target_angle;
    logic [1:0]        segment;
    logic              last;

    modport source (output valid, target_index, target_angle, segment, last, input ready);
    modport sink   (input valid, target_index, target_angle, segment, last, output ready);
endinterface

### src/keyframe_getup_sequencer_core.sv
// Keyframe get-up sequencer: pose memory, segment control, ease ROM, blend pipe.
// Depends on kgs_pkg and the channel interfaces in kgs_if.sv.
// A tick request emits NUM_JOINTS targets, one per cycle while the output is not stalled.
// The next request is taken only once every target of a tick has drained; the division is
// skipped once the count has reached the duration. Reset reloads durations and goes idle.
`timescale 1ns / 1ps

module keyframe_getup_sequencer_core #(
    parameter int NUM_JOINTS       = 30,
    parameter int EASE_TABLE_DEPTH = 1025
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kgs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    kgs_in_if.sink                     in_ch,
    kgs_out_if.source                  out_ch
);

    localparam int JW        = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int IW        = $clog2(EASE_TABLE_DEPTH);
    localparam int DVW       = 16 + IW;
    localparam int CW        = $clog2(IW + 1);
    localparam int EaseLast  = EASE_TABLE_DEPTH - 1;

    typedef logic [16:0] ease_rom_t [EASE_TABLE_DEPTH];

    // Ease entry from a Q30 Taylor series of cos, mirrored in the upper half.
    function automatic logic [16:0] ease_entry(input int unsigned i);
        logic [63:0] m;
        logic [63:0] th;
        logic [63:0] t2;
        logic [63:0] v;
        logic [63:0] p;
        logic [63:0] h;
        logic        low_half;
        low_half = (64'(i) * 64'd2 <= 64'(EaseLast));
        m  = low_half ? 64'(i) : 64'(EaseLast) - 64'(i);
        th = (m * 64'd3373259426) / EaseLast;
        t2 = (th * th) >> 30;
        v  = 64'd1 << 30;
        for (int k = 0; k < 5; k++)
        begin
            p = (t2 * v) >> 30;
            case (k)
                0:       p = p / 90;
                1:       p = p / 56;
                2:       p = p / 30;
                3:       p = p / 12;
                default: p = p / 2;
            endcase
            v = (p >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - p;
        end
        h = ((64'd1 << 30) - v + 64'd16384) >> 15;
        return low_half ? 17'(h) : 17'(64'd65536 - h);
    endfunction

    function automatic ease_rom_t build_ease();
        ease_rom_t r;
        for (int i = 0; i < EASE_TABLE_DEPTH; i++)
        begin
            r[i] = ease_entry(i);
        end
        return r;
    endfunction

    localparam ease_rom_t EASE_ROM = build_ease();

    typedef enum logic [2:0] {
        PH_IDLE, PH_TUCK, PH_PUSHUP, PH_KNEEL, PH_STAND, PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_DIV, S_EASE, S_EMIT, S_DRAIN
    } ctrl_t;

    // Configuration registers.
    logic [15:0] tuck_reg, pushup_reg, kneel_reg, stand_reg;

    // Control state.
    ctrl_t              ctrl_reg;
    phase_t             phase_reg;
    logic               dir_reg;
    logic [15:0]        tick_reg;
    logic [1:0]         seg_reg;
    logic [15:0]        dur_reg;
    logic [DVW-1:0]     dividend_reg;
    logic [15:0]        rem_reg;
    logic [IW-1:0]      quo_reg;
    logic [CW-1:0]      cnt_reg;
    logic [16:0]        ease_reg;
    logic [JW-1:0]      j_reg;

    // Start pose memory and its valid bits.
    kgs_pkg::angle_t    pose_mem [NUM_JOINTS];
    logic [NUM_JOINTS-1:0] pose_ok_reg;
    kgs_pkg::angle_t    pose_rd_reg;
    logic               pose_rd_ok_reg;

    // Blend pipeline.
    logic               s1_v_reg, s2_v_reg, out_valid_reg;
    kgs_pkg::angle_t    s1_kfa_reg, s1_kfb_reg, s2_a_reg;
    logic [JW-1:0]      s1_j_reg, s2_j_reg;
    logic signed [34:0] s2_prod_reg;
    logic [4:0]         out_index_reg;
    kgs_pkg::angle_t    out_angle_reg;
    logic               out_last_reg;

    logic               in_fire, adv, issue, cfg_we, cap_we, pipe_empty;
    logic [JW-1:0]      cap_addr;
    logic [15:0]        dur_sel;
    logic               seg_end;
    logic [16:0]        trial;
    logic               trial_ge;
    kgs_pkg::angle_t    s1_a;
    logic signed [16:0] s1_diff;
    logic signed [34:0] s2_round;
    logic signed [34:0] s2_q;

    assign pready       = 1'b1;
    assign cfg_we       = psel && penable && pwrite;
    assign in_ch.ready  = (ctrl_reg == S_IDLE);
    assign in_fire      = in_ch.valid && (ctrl_reg == S_IDLE);
    assign adv          = !out_valid_reg || out_ch.ready;
    assign issue        = (ctrl_reg == S_EMIT) && adv;
    assign pipe_empty   = !s1_v_reg && !s2_v_reg && !out_valid_reg;
    assign cap_addr     = JW'(in_ch.joint_index);
    assign cap_we       = in_fire && (in_ch.cmd == kgs_pkg::CMD_CAPTURE) &&
                          (phase_reg == PH_IDLE) && (int'(in_ch.joint_index) < NUM_JOINTS);

    // Configuration write and readback.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuck_reg   <= kgs_pkg::TUCK_RESET;
            pushup_reg <= kgs_pkg::PUSHUP_RESET;
            kneel_reg  <= kgs_pkg::KNEEL_RESET;
            stand_reg  <= kgs_pkg::STAND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                kgs_pkg::REG_TUCK:   tuck_reg   <= pwdata[15:0];
                kgs_pkg::REG_PUSHUP: pushup_reg <= pwdata[15:0];
                kgs_pkg::REG_KNEEL:  kneel_reg  <= pwdata[15:0];
                default:             stand_reg  <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            kgs_pkg::REG_TUCK:   prdata = {16'd0, tuck_reg};
            kgs_pkg::REG_PUSHUP: prdata = {16'd0, pushup_reg};
            kgs_pkg::REG_KNEEL:  prdata = {16'd0, kneel_reg};
            default:             prdata = {16'd0, stand_reg};
        endcase
    end

    // Duration of the current segment and its end condition.
    always_comb
    begin
        unique case (phase_reg)
            PH_TUCK:   dur_sel = tuck_reg;
            PH_PUSHUP: dur_sel = pushup_reg;
            PH_KNEEL:  dur_sel = kneel_reg;
            default:   dur_sel = stand_reg;
        endcase
    end
    assign seg_end  = (tick_reg > dur_sel) || (tick_reg == 16'hFFFF);

    // One restoring division step.
    assign trial    = {rem_reg, quo_reg[IW-1]};
    assign trial_ge = (trial >= {1'b0, dur_reg});

    // Sequencer: phase, tick counter, ease index division, joint issue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg     <= S_IDLE;
            phase_reg    <= PH_IDLE;
            dir_reg      <= 1'b0;
            tick_reg     <= 16'd0;
            seg_reg      <= 2'd0;
            dur_reg      <= 16'd0;
            dividend_reg <= '0;
            rem_reg      <= 16'd0;
            quo_reg      <= '0;
            cnt_reg      <= '0;
            ease_reg     <= 17'd0;
            j_reg        <= '0;
        end
        else
        begin
            unique case (ctrl_reg)
                S_IDLE:
                begin
                    if (in_fire && in_ch.cmd == kgs_pkg::CMD_START && phase_reg == PH_IDLE)
                    begin
                        dir_reg   <= in_ch.face_up;
                        phase_reg <= PH_TUCK;
                        tick_reg  <= 16'd0;
                    end
                    else if (in_fire && in_ch.cmd == kgs_pkg::CMD_TICK)
                    begin
                        if (phase_reg == PH_DONE)
                        begin
                            phase_reg <= PH_IDLE;
                            dir_reg   <= 1'b0;
                        end
                        else if (phase_reg != PH_IDLE)
                        begin
                            seg_reg      <= 2'(phase_reg - PH_TUCK);
                            dur_reg      <= dur_sel;
                            dividend_reg <= {{IW{1'b0}}, tick_reg} * {16'd0, IW'(EaseLast)};
                            if (dur_sel == 16'd0 || tick_reg >= dur_sel)
                            begin
                                quo_reg  <= IW'(EaseLast);
                                ctrl_reg <= S_EASE;
                            end
                            else
                            begin
                                ctrl_reg <= S_PREP;
                            end
                            // Segment advance and tick count; the count restarts at one when the segment ends.
                            if (seg_end)
                            begin
                                tick_reg <= 16'd1;
                                unique case (phase_reg)
                                    PH_TUCK:   phase_reg <= PH_PUSHUP;
                                    PH_PUSHUP: phase_reg <= PH_KNEEL;
                                    PH_KNEEL:  phase_reg <= PH_STAND;
                                    default:   phase_reg <= PH_DONE;
                                endcase
                            end
                            else
                            begin
                                tick_reg <= tick_reg + 16'd1;
                            end
                        end
                    end
                end
                S_PREP:
                begin
                    rem_reg  <= dividend_reg[DVW-1:IW];
                    quo_reg  <= dividend_reg[IW-1:0];
                    cnt_reg  <= '0;
                    ctrl_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= trial_ge ? 16'(trial - {1'b0, dur_reg}) : trial[15:0];
                    quo_reg <= {quo_reg[IW-2:0], trial_ge};
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(IW - 1))
                    begin
                        ctrl_reg <= S_EASE;
                    end
                end
                S_EASE:
                begin
                    ease_reg <= EASE_ROM[quo_reg];
                    j_reg    <= '0;
                    ctrl_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (adv)
                    begin
                        j_reg <= j_reg + JW'(1);
                        if (j_reg == JW'(NUM_JOINTS - 1))
                        begin
                            ctrl_reg <= S_DRAIN;
                        end
                    end
                end
                default:
                begin
                    if (pipe_empty)
                    begin
                        ctrl_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Pose memory: capture writes while idle, joint reads while emitting.
    always_ff @(posedge clk)
    begin
        if (cap_we)
        begin
            pose_mem[cap_addr] <= in_ch.joint_angle;
        end
        if (issue)
        begin
            pose_rd_reg <= pose_mem[j_reg];
        end
    end

    // Valid bits of the pose memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_ok_reg    <= '0;
            pose_rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (cap_we)
            begin
                pose_ok_reg[cap_addr] <= 1'b1;
            end
            if (issue)
            begin
                pose_rd_ok_reg <= pose_ok_reg[j_reg];
            end
        end
    end

    // Pipeline valid bits; the whole pipe stalls while a target waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg      <= issue;
            s2_v_reg      <= s1_v_reg;
            out_valid_reg <= s2_v_reg;
        end
    end

    // Blend datapath: begin pose select and difference times ease.
    always_comb
    begin
        if (seg_reg == 2'd0)
        begin
            s1_a = pose_rd_ok_reg ? pose_rd_reg : 16'sd0;
        end
        else
        begin
            s1_a = s1_kfa_reg;
        end
        s1_diff = 17'(s1_kfb_reg) - 17'(s1_a);
    end

    // Round half up and add to the begin pose.
    assign s2_round = s2_prod_reg + 35'sd32768;
    assign s2_q     = s2_round >>> 16;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (issue)
            begin
                s1_kfa_reg <= (seg_reg == 2'd0) ? 16'sd0 :
                              kgs_pkg::kf_value(dir_reg, 2'(seg_reg - 2'd1), 6'(j_reg));
                s1_kfb_reg <= kgs_pkg::kf_value(dir_reg, seg_reg, 6'(j_reg));
                s1_j_reg   <= j_reg;
            end
            s2_prod_reg   <= s1_diff * $signed({1'b0, ease_reg});
            s2_a_reg      <= s1_a;
            s2_j_reg      <= s1_j_reg;
            out_index_reg <= 5'(s2_j_reg);
            out_angle_reg <= s2_a_reg + s2_q[15:0];
            out_last_reg  <= (s2_j_reg == JW'(NUM_JOINTS - 1));
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.target_index = out_index_reg;
    assign out_ch.target_angle = out_angle_reg;
    assign out_ch.segment      = seg_reg;
    assign out_ch.last         = out_last_reg;

endmodule

### src/kgs_checker.sv
// Port-level checks of the get-up sequencer, bound to the top level.
// Depends on keyframe_getup_sequencer_core and its channel interfaces.
`timescale 1ns / 1ps

module kgs_port_checks #(
    parameter int NUM_JOINTS = 30
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] out_index,
    input logic [1:0] out_segment,
    input logic       out_last
);

    // A waiting target holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_last))
        else $error("target dropped or changed while stalled");

    // No new request is taken while targets are pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request accepted during target emission");

    // The last flag marks only the final joint.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_index == 5'(NUM_JOINTS - 1))
        else $error("last flag on wrong joint");

    // After the last target of a tick, the output goes quiet.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("target after last of tick");

    // Segment tag stays fixed within a tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> $stable(out_segment))
        else $error("segment changed within a tick");

endmodule

bind keyframe_getup_sequencer_core kgs_port_checks #(.NUM_JOINTS(NUM_JOINTS)) u_kgs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_index   (out_ch.target_index),
    .out_segment (out_ch.segment),
    .out_last    (out_ch.last)
);
